// File: design/imufp_pkg.sv
// ----------------------------------------------------------------------------
// imufp_pkg
// Shared constants and types for the IMU frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package imufp_pkg;

  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int NUM_HELD = 9;
  localparam int IDX_W    = 4;
  localparam int OUT_W    = BYTE_W + NUM_HELD * COUNT_W;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h51;
  localparam logic [BYTE_W-1:0] TYPE_RATE  = 8'h52;
  localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;

  // Position of the checksum byte within a frame, and the last stored byte.
  localparam logic [IDX_W-1:0] CHECK_POS    = 4'd10;
  localparam logic [IDX_W-1:0] LAST_STORED  = 4'd7;
  localparam logic [IDX_W-1:0] FIRST_STORED = 4'd1;

  // What the framer reports about the byte it currently looks at.
  typedef struct packed {
    logic                good;
    logic [BYTE_W-1:0]   ptype;
    logic [COUNT_W-1:0]  word0;
    logic [COUNT_W-1:0]  word1;
    logic [COUNT_W-1:0]  word2;
  } imufp_frame_t;

endpackage

`default_nettype wire

// File: design/imufp_framer.sv
// ----------------------------------------------------------------------------
// imufp_framer
// Start-byte hunt, byte counting, running checksum and frame byte capture.
// ----------------------------------------------------------------------------
`default_nettype none

module imufp_framer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          consume,
  input  wire logic [imufp_pkg::BYTE_W-1:0]  rx_byte,
  output imufp_pkg::imufp_frame_t            frame
);
  import imufp_pkg::*;

  logic              in_frame, in_frame_next;
  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] frame_bytes [7];

  always_comb begin
    in_frame_next    = in_frame;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    if (consume) begin
      if (!in_frame) begin
        if (rx_byte == START_BYTE) begin
          in_frame_next    = 1'b1;
          byte_index_next  = FIRST_STORED;
          running_sum_next = START_BYTE;
        end
      end else if (byte_index < CHECK_POS) begin
        running_sum_next = running_sum + rx_byte;
        byte_index_next  = byte_index + 1'b1;
      end else begin
        in_frame_next    = 1'b0;
        byte_index_next  = '0;
        running_sum_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_index  <= '0;
      running_sum <= '0;
    end else begin
      in_frame    <= in_frame_next;
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
    end
  end

  // Frame bytes 1..7 are kept; bytes 8 and 9 only enter the checksum.
  always_ff @(posedge clk) begin
    if (consume && in_frame && byte_index >= FIRST_STORED && byte_index <= LAST_STORED) begin
      frame_bytes[3'(byte_index - FIRST_STORED)] <= rx_byte;
    end
  end

  always_comb begin
    frame.good  = in_frame && (byte_index == CHECK_POS) && (rx_byte == running_sum);
    frame.ptype = frame_bytes[0];
    frame.word0 = {frame_bytes[2], frame_bytes[1]};
    frame.word1 = {frame_bytes[4], frame_bytes[3]};
    frame.word2 = {frame_bytes[6], frame_bytes[5]};
  end

endmodule

`default_nettype wire

// File: design/imufp_holder.sv
// ----------------------------------------------------------------------------
// imufp_holder
// Holds the nine raw counts and loads the triple chosen by a good frame.
// ----------------------------------------------------------------------------
`default_nettype none

module imufp_holder (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       load,
  input  wire imufp_pkg::imufp_frame_t                    frame,
  output logic [imufp_pkg::NUM_HELD*imufp_pkg::COUNT_W-1:0] held_flat
);
  import imufp_pkg::*;

  logic [COUNT_W-1:0] held_values [NUM_HELD];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_HELD; i++) begin
        held_values[i] <= '0;
      end
    end else if (load) begin
      case (frame.ptype)
        TYPE_ACCEL: begin
          held_values[0] <= frame.word0;
          held_values[1] <= frame.word1;
          held_values[2] <= frame.word2;
        end
        TYPE_RATE: begin
          held_values[3] <= frame.word0;
          held_values[4] <= frame.word1;
          held_values[5] <= frame.word2;
        end
        TYPE_ANGLE: begin
          held_values[6] <= frame.word0;
          held_values[7] <= frame.word1;
          held_values[8] <= frame.word2;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_HELD; i++) begin
      held_flat[i*COUNT_W +: COUNT_W] = held_values[i];
    end
  end

endmodule

`default_nettype wire

// File: design/imu_frame_parser.sv
// Path: a byte that completes a good frame passes the input register, then the result registers, before it shows.
// Throughput: one byte per cycle; the input register only holds while a finished
// result waits at the output and the next byte would complete another frame.
// Reset: synchronous, active high; clears the hunt state, the nine held counts
// and both valid flags. Frame byte storage is not cleared.
// ----------------------------------------------------------------------------
// imu_frame_parser
// Byte-serial parser for 11-byte IMU frames that open with 0x55.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_frame_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input stream, one received byte per item.
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,  // [7:0] rx_byte
  // Result stream, one item per good frame.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // m_tdata from bit 0 up: packet_type (8), accel_x, accel_y, accel_z,
  // rate_x, rate_y, rate_z, angle_roll, pitch_angle, yaw_angle (16 each).
  output logic [imufp_pkg::OUT_W-1:0]         m_tdata
);
  import imufp_pkg::*;

  // Input register: the byte under work sits here. It moves on
  // whenever it cannot produce a result, or when the result slot is free.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_free;
  logic              consume;
  logic [BYTE_W-1:0] packet_type;
  logic [NUM_HELD*COUNT_W-1:0] held_flat;
  imufp_frame_t      frame;

  assign out_free = !m_tvalid || m_tready;
  assign consume  = in_valid && (!frame.good || out_free);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  imufp_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .consume (consume),
    .rx_byte (in_byte),
    .frame   (frame)
  );

  // The held counts only change on a good frame, and a good frame only goes
  // through when the result slot is free, so the held registers double as
  // the result payload while a result waits.
  imufp_holder u_holder (
    .clk       (clk),
    .rst       (rst),
    .load      (consume && frame.good),
    .frame     (frame),
    .held_flat (held_flat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (consume && frame.good) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && frame.good) begin
      packet_type <= frame.ptype;
    end
  end

  assign m_tdata = {held_flat, packet_type};

endmodule

`default_nettype wire

// File: design/imufp_checker.sv
// ----------------------------------------------------------------------------
// imufp_checker
// Port-level checks on the IMU frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module imufp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [imufp_pkg::OUT_W-1:0] m_tdata
);
  import imufp_pkg::*;

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result payload changed while stalled");

  // With no result waiting, the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty result slot");

  // Reset leaves no result pending and the input open.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("state after reset not clean");

  // A result can only appear after an input byte was seen.
  a_result_needs_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid, 2) || $past(!s_tready, 1) || $past(s_tvalid, 1)
      || $past(!s_tready, 2))
    else $error("result appeared without input");

endmodule

bind imu_frame_parser imufp_checker u_imufp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
